>>> sv/gmcp_pkg.sv
// Shared types and constants for the grid minimum-cost path block.
// Used by gmcp_ctrl, gmcp_datapath and grid_min_cost_path; no dependencies.
package gmcp_pkg;

    localparam int GRID_DIM_DEF = 16;
    localparam int CFG_W        = 5;
    localparam int REQ_W        = 2;
    localparam int POS_W        = 4;
    localparam int COST_W       = 16;
    localparam int DIST_W       = 32;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 32;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;
    localparam logic [CFG_W-1:0] SIDE_RST = 5'd16;

    // Request kinds carried in the low bits of the input tdata
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD = 2'd0,
        REQ_RUN  = 2'd1,
        REQ_READ = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_READ_OUT,
        OP_CLR,
        OP_INIT_RD,
        OP_INIT_WR,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_SETTLE,
        OP_NB_RD,
        OP_NB_WR,
        OP_FIN_RD,
        OP_FIN_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] nb;     // neighbor: 0 right, 1 down, 2 up, 3 left
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic clr_last;
        logic scan_last;
        logic found;
    } t_dp_sts;

endpackage

>>> sv/gmcp_datapath.sv
// Datapath of the grid minimum-cost path block: cost, distance and frontier
// memories, scan for the cheapest open cell, relaxation and result register.
// Depends on gmcp_pkg.
module gmcp_datapath #(
    parameter int GRID_DIM = gmcp_pkg::GRID_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gmcp_pkg::t_dp_cmd                   i_cmd,
    output gmcp_pkg::t_dp_sts                   o_sts,
    input  logic [gmcp_pkg::POS_W-1:0]          i_row,
    input  logic [gmcp_pkg::POS_W-1:0]          i_col,
    input  logic [gmcp_pkg::COST_W-1:0]         i_cost,
    input  logic [$clog2(GRID_DIM)-1:0]         i_side_m1,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [gmcp_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    localparam int CELLS = GRID_DIM * GRID_DIM;
    localparam int IW    = $clog2(CELLS);
    localparam int RW    = $clog2(GRID_DIM);
    localparam int DW    = gmcp_pkg::DIST_W;
    localparam int CW    = gmcp_pkg::COST_W;
    localparam int FW    = DW + 2;   // {settled, valid, tentative cost}

    function automatic logic [IW-1:0] f_idx(input int r, input int c);
        return IW'(r * GRID_DIM + c);
    endfunction

    // Memories
    logic [CW-1:0] r_cost_mem [CELLS];
    logic [DW-1:0] r_dist_mem [CELLS];
    logic [FW-1:0] r_fr_mem   [CELLS];
    logic [CW-1:0] r_cost_q;
    logic [DW-1:0] r_dist_q;
    logic [FW-1:0] r_fr_q;

    logic [IW-1:0] cost_ra, dist_ra, fr_ra, fr_wa, dist_wa, cost_wa;
    logic          cost_we, dist_we, fr_we;
    logic [FW-1:0] fr_wd;
    logic [DW-1:0] dist_wd;

    // Control and search registers
    logic [IW-1:0] r_clr_ptr;
    logic [RW-1:0] r_sc_r, r_sc_c, r_p_r, r_p_c, r_best_r, r_best_c;
    logic          r_p_vld, r_found, r_rd_in, r_out_vld;
    logic [DW-1:0] r_best, r_out;

    logic [IW-1:0] req_idx;
    logic          req_in;
    logic          nb_ok;
    logic [RW-1:0] nb_r, nb_c;
    logic [DW-1:0] nd;
    logic          relax;
    logic          out_free;

    assign req_idx  = f_idx(int'(i_row), int'(i_col));
    assign req_in   = (int'(i_row) < GRID_DIM) && (int'(i_col) < GRID_DIM);
    assign out_free = !r_out_vld || i_m_tready;

    // Pick the neighbor cell of the settled cell
    always_comb begin
        nb_ok = 1'b0;
        nb_r  = r_best_r;
        nb_c  = r_best_c;
        case (i_cmd.nb)
            2'd0: begin
                nb_ok = r_best_c < i_side_m1;
                nb_c  = r_best_c + 1'b1;
            end
            2'd1: begin
                nb_ok = r_best_r < i_side_m1;
                nb_r  = r_best_r + 1'b1;
            end
            2'd2: begin
                nb_ok = r_best_r != '0;
                nb_r  = r_best_r - 1'b1;
            end
            default: begin
                nb_ok = r_best_c != '0;
                nb_c  = r_best_c - 1'b1;
            end
        endcase
    end

    // Relaxation of one neighbor
    assign nd    = r_best + DW'(r_cost_q);
    assign relax = nb_ok && !r_fr_q[FW-1] && (!r_fr_q[FW-2] || nd < r_fr_q[DW-1:0]);

    // Memory port selection
    always_comb begin
        cost_ra = '0;
        dist_ra = f_idx(int'(i_side_m1), int'(i_side_m1));
        fr_ra   = f_idx(int'(r_sc_r), int'(r_sc_c));
        cost_we = 1'b0;
        cost_wa = req_idx;
        dist_we = 1'b0;
        dist_wa = f_idx(int'(r_best_r), int'(r_best_c));
        dist_wd = r_best;
        fr_we   = 1'b0;
        fr_wa   = r_clr_ptr;
        fr_wd   = '0;
        case (i_cmd.op)
            gmcp_pkg::OP_LOAD: cost_we = req_in;
            gmcp_pkg::OP_READ: dist_ra = req_idx;
            gmcp_pkg::OP_CLR:  fr_we   = 1'b1;
            gmcp_pkg::OP_INIT_WR: begin
                fr_we = 1'b1;
                fr_wa = '0;
                fr_wd = {2'b01, DW'(r_cost_q)};
            end
            gmcp_pkg::OP_SETTLE: begin
                fr_we   = 1'b1;
                fr_wa   = dist_wa;
                fr_wd   = {2'b10, r_best};
                dist_we = 1'b1;
            end
            gmcp_pkg::OP_NB_RD: begin
                cost_ra = f_idx(int'(nb_r), int'(nb_c));
                fr_ra   = f_idx(int'(nb_r), int'(nb_c));
            end
            gmcp_pkg::OP_NB_WR: begin
                fr_we = relax;
                fr_wa = f_idx(int'(nb_r), int'(nb_c));
                fr_wd = {2'b01, nd};
            end
            default: begin
            end
        endcase
    end

    // Memory writes and registered reads
    always_ff @(posedge i_clk) begin
        if (cost_we) begin
            r_cost_mem[cost_wa] <= i_cost;
        end
        if (dist_we) begin
            r_dist_mem[dist_wa] <= dist_wd;
        end
        if (fr_we) begin
            r_fr_mem[fr_wa] <= fr_wd;
        end
        r_cost_q <= r_cost_mem[cost_ra];
        r_dist_q <= r_dist_mem[dist_ra];
        r_fr_q   <= r_fr_mem[fr_ra];
    end

    // Clear sweep, scan and best tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ptr <= '0;
            r_p_vld   <= 1'b0;
            r_found   <= 1'b0;
            r_sc_r    <= '0;
            r_sc_c    <= '0;
        end else begin
            if (i_cmd.op == gmcp_pkg::OP_CLR) begin
                r_clr_ptr <= (r_clr_ptr == IW'(CELLS - 1)) ? '0 : r_clr_ptr + 1'b1;
            end
            r_p_vld <= 1'b0;
            if (i_cmd.op == gmcp_pkg::OP_SCAN_INIT) begin
                r_sc_r  <= '0;
                r_sc_c  <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.op == gmcp_pkg::OP_SCAN) begin
                r_p_vld <= 1'b1;
                r_p_r   <= r_sc_r;
                r_p_c   <= r_sc_c;
                if (r_sc_c == i_side_m1) begin
                    r_sc_c <= '0;
                    r_sc_r <= r_sc_r + 1'b1;
                end else begin
                    r_sc_c <= r_sc_c + 1'b1;
                end
            end
            if (r_p_vld && r_fr_q[FW-2] && !r_fr_q[FW-1] &&
                (!r_found || r_fr_q[DW-1:0] < r_best)) begin
                r_found  <= 1'b1;
                r_best   <= r_fr_q[DW-1:0];
                r_best_r <= r_p_r;
                r_best_c <= r_p_c;
            end
        end
    end

    // Hold the range flag of a read request
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == gmcp_pkg::OP_READ) begin
            r_rd_in <= req_in;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.op == gmcp_pkg::OP_READ_OUT ||
                     i_cmd.op == gmcp_pkg::OP_FIN_OUT) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == gmcp_pkg::OP_READ_OUT) begin
            r_out <= r_rd_in ? r_dist_q : '0;
        end else if (i_cmd.op == gmcp_pkg::OP_FIN_OUT) begin
            r_out <= r_dist_q;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

    assign o_sts.out_free  = out_free;
    assign o_sts.clr_last  = r_clr_ptr == IW'(CELLS - 1);
    assign o_sts.scan_last = (r_sc_r == i_side_m1) && (r_sc_c == i_side_m1);
    assign o_sts.found     = r_found;

endmodule

>>> sv/gmcp_ctrl.sv
// Controller of the grid minimum-cost path block: request handshake and the
// search sequence (clear, seed, scan, settle, relax, answer). Depends on gmcp_pkg.
module gmcp_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [gmcp_pkg::REQ_W-1:0]    i_req,
    input  gmcp_pkg::t_dp_sts             i_sts,
    output gmcp_pkg::t_dp_cmd             o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_OUT,
        S_CLR,
        S_INIT_RD,
        S_INIT_WR,
        S_SCAN_INIT,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_SETTLE,
        S_NB_RD,
        S_NB_WR,
        S_FIN_RD,
        S_FIN_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_nb, n_nb;
    logic       accept;

    assign o_s_tready = (r_state == S_IDLE) && i_sts.out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    // Next state and command
    always_comb begin
        n_state  = r_state;
        n_nb     = r_nb;
        o_cmd.nb = r_nb;
        o_cmd.op = gmcp_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (gmcp_pkg::t_req'(i_req))
                        gmcp_pkg::REQ_LOAD: o_cmd.op = gmcp_pkg::OP_LOAD;
                        gmcp_pkg::REQ_READ: begin
                            o_cmd.op = gmcp_pkg::OP_READ;
                            n_state  = S_RD_OUT;
                        end
                        gmcp_pkg::REQ_RUN: n_state = S_CLR;
                        default: begin
                        end
                    endcase
                end
            end
            S_RD_OUT: begin
                o_cmd.op = gmcp_pkg::OP_READ_OUT;
                n_state  = S_IDLE;
            end
            S_CLR: begin
                o_cmd.op = gmcp_pkg::OP_CLR;
                if (i_sts.clr_last) begin
                    n_state = S_INIT_RD;
                end
            end
            S_INIT_RD: begin
                o_cmd.op = gmcp_pkg::OP_INIT_RD;
                n_state  = S_INIT_WR;
            end
            S_INIT_WR: begin
                o_cmd.op = gmcp_pkg::OP_INIT_WR;
                n_state  = S_SCAN_INIT;
            end
            S_SCAN_INIT: begin
                o_cmd.op = gmcp_pkg::OP_SCAN_INIT;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.op = gmcp_pkg::OP_SCAN;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DECIDE;
            S_DECIDE: n_state = i_sts.found ? S_SETTLE : S_FIN_RD;
            S_SETTLE: begin
                o_cmd.op = gmcp_pkg::OP_SETTLE;
                n_nb     = 2'd0;
                n_state  = S_NB_RD;
            end
            S_NB_RD: begin
                o_cmd.op = gmcp_pkg::OP_NB_RD;
                n_state  = S_NB_WR;
            end
            S_NB_WR: begin
                o_cmd.op = gmcp_pkg::OP_NB_WR;
                if (r_nb == 2'd3) begin
                    n_state = S_SCAN_INIT;
                end else begin
                    n_nb    = r_nb + 1'b1;
                    n_state = S_NB_RD;
                end
            end
            S_FIN_RD: begin
                o_cmd.op = gmcp_pkg::OP_FIN_RD;
                n_state  = S_FIN_OUT;
            end
            S_FIN_OUT: begin
                // hold the corner read until the result register frees up
                if (i_sts.out_free) begin
                    o_cmd.op = gmcp_pkg::OP_FIN_OUT;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.op = gmcp_pkg::OP_FIN_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nb    <= 2'd0;
        end else begin
            r_state <= n_state;
            r_nb    <= n_nb;
        end
    end

endmodule

>>> sv/grid_min_cost_path.sv
// Grid minimum-cost path: a load is taken every cycle while the result register is free;
// a read answers through the registered distance read and the result register, and holds
// off new requests until its answer is there. A run clears and seeds the frontier memory,
// then per settled cell scans the grid in use for the cheapest open cell, settles it and
// relaxes its four neighbors; a last scan that finds none reads the corner and answers.
// A stalled result holds new requests. Synchronous active-low reset clears control state and sets grid_side to 16.
module grid_min_cost_path #(
    parameter int GRID_DIM = gmcp_pkg::GRID_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // req_type[1:0], row[5:2], col[9:6], cell_cost[25:10], zero pad
    input  logic [gmcp_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // path_cost[31:0]
    output logic [gmcp_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [gmcp_pkg::APB_ADDR_W-1:0]     i_paddr,
    input  logic [gmcp_pkg::APB_DATA_W-1:0]     i_pwdata,
    output logic [gmcp_pkg::APB_DATA_W-1:0]     o_prdata,
    output logic                                o_pready
);

    localparam int RW = $clog2(GRID_DIM);

    logic [gmcp_pkg::CFG_W-1:0] r_side;
    logic [RW-1:0]              side_m1;
    gmcp_pkg::t_dp_cmd          cmd;
    gmcp_pkg::t_dp_sts          sts;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= gmcp_pkg::SIDE_RST;
        end else if (i_psel && i_penable && i_pwrite && !i_paddr[2]) begin
            r_side <= i_pwdata[gmcp_pkg::CFG_W-1:0];
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = i_paddr[2] ? '0 : gmcp_pkg::APB_DATA_W'(r_side);

    // Saturate the side in use to 1..GRID_DIM
    always_comb begin
        int s;
        s = (r_side == '0) ? 1 : int'(r_side);
        if (s > GRID_DIM) begin
            s = GRID_DIM;
        end
        side_m1 = RW'(s - 1);
    end

    gmcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_req      (i_s_tdata[1:0]),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gmcp_datapath #(
        .GRID_DIM (GRID_DIM)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_row      (i_s_tdata[5:2]),
        .i_col      (i_s_tdata[9:6]),
        .i_cost     (i_s_tdata[25:10]),
        .i_side_m1  (side_m1),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

>>> dv/grid_min_cost_path_test.sv
// Self-checking testbench for grid_min_cost_path: a directed table, then random phases.
// Each phase sets grid_side over APB; results are checked against an in-bench path predictor.
// Depends on gmcp_pkg and the grid_min_cost_path RTL.
`timescale 1ns / 1ps

module grid_min_cost_path_test;

    localparam int DIM        = gmcp_pkg::GRID_DIM_DEF;
    localparam int CELL_COUNT = DIM * DIM;
    localparam int RAND_ITEMS = 1150;
    localparam int CYCLE_CAP  = 3000000;
    localparam int DRAIN_WAIT = 20;
    localparam logic [gmcp_pkg::APB_ADDR_W-1:0] ADDR_GRID_SIDE = 3'd0;

    // One row of the directed stimulus table
    typedef struct {
        gmcp_pkg::t_req req;
        logic [3:0]     row;
        logic [3:0]     col;
        logic [15:0]    cost;
        bit             has_exp;
        logic [31:0]    exp_cost;
    } t_stim_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    // req_type[1:0], row[5:2], col[9:6], cell_cost[25:10], zero pad
    logic [gmcp_pkg::IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    // path_cost[31:0]
    logic [gmcp_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                             i_psel = 1'b0;
    logic                             i_penable = 1'b0;
    logic                             i_pwrite = 1'b0;
    logic [gmcp_pkg::APB_ADDR_W-1:0]  i_paddr = '0;
    logic [gmcp_pkg::APB_DATA_W-1:0]  i_pwdata = '0;
    logic [gmcp_pkg::APB_DATA_W-1:0]  o_prdata;
    logic                             o_pready;

    grid_min_cost_path #(.GRID_DIM(DIM)) uut (.*);

    // Predictor state
    logic [15:0] cell_cost_mem [CELL_COUNT];
    logic [31:0] path_dist_mem [CELL_COUNT];
    bit          cost_loaded   [CELL_COUNT];
    bit          dist_known    [CELL_COUNT];
    logic [4:0]  side_reg = gmcp_pkg::SIDE_RST;

    logic [31:0] pending_costs[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          sender_idles = 1'b0;
    bit          receiver_stalls = 1'b0;
    int          idle_pct = 72;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // End the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic int side_now();
        int s;
        s = side_reg;
        if (s == 0) s = 1;
        if (s > DIM) s = DIM;
        return s;
    endfunction

    // Minimum-cost search from the top-left cell; fills path_dist_mem for the grid in use
    function automatic logic [31:0] predict_corner_cost();
        bit          done [CELL_COUNT];
        bit          open [CELL_COUNT];
        logic [31:0] tent [CELL_COUNT];
        int          s, best_idx, r, c, nr, nc, k, n;
        logic [31:0] best;
        bit          found;
        s = side_now();
        for (k = 0; k < CELL_COUNT; k++) begin
            done[k] = 1'b0;
            open[k] = 1'b0;
            tent[k] = '0;
        end
        open[0] = 1'b1;
        tent[0] = cell_cost_mem[0];
        forever begin
            found = 1'b0;
            best = '0;
            best_idx = 0;
            for (k = 0; k < CELL_COUNT; k++) begin
                if (k / DIM < s && k % DIM < s && open[k] && !done[k]
                        && (!found || tent[k] < best)) begin
                    found = 1'b1;
                    best = tent[k];
                    best_idx = k;
                end
            end
            if (!found) break;
            done[best_idx] = 1'b1;
            open[best_idx] = 1'b0;
            path_dist_mem[best_idx] = best;
            dist_known[best_idx] = 1'b1;
            r = best_idx / DIM;
            c = best_idx % DIM;
            for (k = 0; k < 4; k++) begin
                nr = r + ((k == 1) ? 1 : (k == 2) ? -1 : 0);
                nc = c + ((k == 0) ? 1 : (k == 3) ? -1 : 0);
                if (nr >= 0 && nc >= 0 && nr < s && nc < s) begin
                    n = nr * DIM + nc;
                    if (!done[n] && (!open[n] || best + cell_cost_mem[n] < tent[n])) begin
                        open[n] = 1'b1;
                        tent[n] = best + cell_cost_mem[n];
                    end
                end
            end
        end
        return path_dist_mem[(s - 1) * DIM + (s - 1)];
    endfunction

    // Send one request, wait for acceptance, then update the prediction
    task automatic send_request(input gmcp_pkg::t_req req, input logic [3:0] row,
                                input logic [3:0] col, input logic [15:0] cost,
                                input bit has_exp, input logic [31:0] exp_cost);
        logic [31:0] predicted;
        int          idx;
        if (sender_idles) begin
            if ($urandom_range(99) < idle_pct) begin
                i_s_tvalid <= 1'b0;
                do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'b0, cost, col, row, req};
        // Ready is stable between edges; look at it mid-cycle
        forever begin
            @(negedge i_clk);
            if (o_s_tready) break;
        end
        @(posedge i_clk);
        idx = row * DIM + col;
        case (req)
            gmcp_pkg::REQ_LOAD: begin
                cell_cost_mem[idx] = cost;
                cost_loaded[idx] = 1'b1;
            end
            gmcp_pkg::REQ_RUN: begin
                predicted = predict_corner_cost();
                if (has_exp && predicted !== exp_cost)
                    report_mismatch($sformatf("table row expects %0d, predictor %0d",
                                              exp_cost, predicted));
                pending_costs.push_back(predicted);
            end
            gmcp_pkg::REQ_READ: begin
                predicted = path_dist_mem[idx];
                if (has_exp && predicted !== exp_cost)
                    report_mismatch($sformatf("table row expects %0d, predictor %0d",
                                              exp_cost, predicted));
                pending_costs.push_back(predicted);
            end
            default: ;
        endcase
    endtask

    // Drop valid and let the block settle before a register write
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_costs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_grid_side(input logic [31:0] value);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= ADDR_GRID_SIDE;
        i_pwdata  <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        side_reg = value[4:0];
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: hold ready or stall at random
    always @(posedge i_clk) begin
        i_m_tready <= receiver_stalls ? ($urandom_range(99) >= idle_pct) : 1'b1;
    end

    // Compare each returned cost with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_costs.size() == 0) begin
                report_mismatch($sformatf("unexpected path_cost %0d", o_m_tdata));
            end else begin
                if (o_m_tdata !== pending_costs[0])
                    report_mismatch($sformatf("path_cost %0d, predicted %0d",
                                              o_m_tdata, pending_costs[0]));
                void'(pending_costs.pop_front());
            end
        end
    end

    function automatic logic [15:0] random_cost();
        case ($urandom_range(9))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'($urandom);
            default: return 16'($urandom_range(50));
        endcase
    endfunction

    t_stim_row dir_table[] = '{
        '{gmcp_pkg::REQ_LOAD, 4'd0,  4'd0,  16'hFFFF, 1'b0, 32'd0},
        '{gmcp_pkg::REQ_LOAD, 4'd0,  4'd1,  16'h0000, 1'b0, 32'd0},
        '{gmcp_pkg::REQ_LOAD, 4'd1,  4'd0,  16'hFFFF, 1'b0, 32'd0},
        '{gmcp_pkg::REQ_LOAD, 4'd1,  4'd1,  16'hFFFF, 1'b0, 32'd0},
        '{gmcp_pkg::REQ_RUN,  4'd0,  4'd0,  16'h0000, 1'b1, 32'd131070},
        '{gmcp_pkg::REQ_READ, 4'd0,  4'd0,  16'h0000, 1'b1, 32'd65535},
        '{gmcp_pkg::REQ_READ, 4'd0,  4'd1,  16'h0000, 1'b1, 32'd65535},
        '{gmcp_pkg::REQ_READ, 4'd1,  4'd0,  16'h0000, 1'b1, 32'd131070},
        '{gmcp_pkg::REQ_NONE, 4'hF,  4'hF,  16'hFFFF, 1'b0, 32'd0},
        '{gmcp_pkg::REQ_LOAD, 4'd15, 4'd15, 16'hFFFF, 1'b0, 32'd0},
        '{gmcp_pkg::REQ_LOAD, 4'd0,  4'd0,  16'h0000, 1'b0, 32'd0},
        '{gmcp_pkg::REQ_LOAD, 4'd1,  4'd1,  16'h0001, 1'b0, 32'd0},
        '{gmcp_pkg::REQ_RUN,  4'd0,  4'd0,  16'h0000, 1'b1, 32'd1},
        '{gmcp_pkg::REQ_READ, 4'd1,  4'd1,  16'h0000, 1'b1, 32'd1},
        '{gmcp_pkg::REQ_READ, 4'd0,  4'd0,  16'h0000, 1'b1, 32'd0},
        '{gmcp_pkg::REQ_LOAD, 4'd1,  4'd0,  16'h0000, 1'b0, 32'd0},
        '{gmcp_pkg::REQ_RUN,  4'd0,  4'd0,  16'h0000, 1'b0, 32'd0},
        '{gmcp_pkg::REQ_READ, 4'd1,  4'd0,  16'h0000, 1'b0, 32'd0}
    };

    int phase_sides[] = '{3, 1, 0, 5, 31, 2, 7, 4, 16, 6, 12, 3};

    initial begin
        int          ph, done_items, budget, runs, run_cap, pick, s, k, idx, tries, total;
        bit          region_ready;
        logic [3:0]  r, c;
        for (k = 0; k < CELL_COUNT; k++) begin
            cell_cost_mem[k] = '0;
            path_dist_mem[k] = '0;
            cost_loaded[k] = 1'b0;
            dist_known[k] = 1'b0;
        end
        total = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on a two-by-two grid
        write_grid_side(32'd2);
        foreach (dir_table[i])
            send_request(dir_table[i].req, dir_table[i].row, dir_table[i].col,
                         dir_table[i].cost, dir_table[i].has_exp, dir_table[i].exp_cost);

        // Random phases, each with its own side and idling mode
        for (ph = 0; ph < phase_sides.size(); ph++) begin
            wait_idle();
            write_grid_side({$urandom} & 32'hFFFF_FFE0 | 32'(phase_sides[ph]));
            case (ph % 4)
                0: begin sender_idles = 1'b0; receiver_stalls = 1'b0; idle_pct = 72; end
                1: begin sender_idles = 1'b1; receiver_stalls = 1'b0; idle_pct = 72; end
                2: begin sender_idles = 1'b0; receiver_stalls = 1'b1; idle_pct = 72; end
                default: begin
                    sender_idles = 1'b1;
                    receiver_stalls = 1'b1;
                    idle_pct = 28;
                end
            endcase
            budget = (RAND_ITEMS - total) / (phase_sides.size() - ph);
            s = side_now();
            run_cap = (s > 8) ? 2 : 12;
            runs = 0;
            done_items = 0;
            while (done_items < budget || runs == 0) begin
                pick = $urandom_range(99);
                r = 4'($urandom);
                c = 4'($urandom);
                if (pick < 5) begin
                    send_request(gmcp_pkg::REQ_NONE, r, c, 16'($urandom), 1'b0, '0);
                    done_items++;
                    continue;
                end
                region_ready = 1'b1;
                idx = 0;
                for (k = 0; k < s * s; k++) begin
                    if (!cost_loaded[(k / s) * DIM + k % s]) begin
                        region_ready = 1'b0;
                        idx = (k / s) * DIM + k % s;
                    end
                end
                if (!region_ready && pick >= 40) begin
                    // Fill the grid in use before searching it
                    send_request(gmcp_pkg::REQ_LOAD, 4'(idx / DIM), 4'(idx % DIM),
                                 random_cost(), 1'b0, '0);
                end else if (pick < 40) begin
                    if ($urandom_range(3) != 0) begin
                        r = 4'($urandom_range(s - 1));
                        c = 4'($urandom_range(s - 1));
                    end
                    send_request(gmcp_pkg::REQ_LOAD, r, c, random_cost(), 1'b0, '0);
                end else if (pick < 90 || runs >= run_cap) begin
                    // Read a cell whose distance is known
                    tries = 0;
                    while (!dist_known[r * DIM + c] && tries < 64) begin
                        r = 4'($urandom_range(s - 1));
                        c = 4'($urandom_range(s - 1));
                        tries++;
                    end
                    if (dist_known[r * DIM + c])
                        send_request(gmcp_pkg::REQ_READ, r, c, 16'($urandom), 1'b0, '0);
                    else
                        send_request(gmcp_pkg::REQ_READ, 4'd0, 4'd0, 16'($urandom),
                                     1'b0, '0);
                end else begin
                    send_request(gmcp_pkg::REQ_RUN, r, c, 16'($urandom), 1'b0, '0);
                    runs++;
                end
                done_items++;
            end
            total += done_items;
        end

        // Drain and settle
        i_s_tvalid <= 1'b0;
        while (pending_costs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/gmcp_pkg.sv
sv/gmcp_datapath.sv
sv/gmcp_ctrl.sv
sv/grid_min_cost_path.sv
dv/grid_min_cost_path_test.sv
